>>> sv/trn_pkg.sv
// Shared types and protocol constants for the telnet receive negotiator.
// No dependencies; imported by the top level and its checker.
package trn_pkg;

  typedef logic [7:0] octet_t;

  // longest reply burst caused by one received byte
  localparam int MaxBurst = 10;
  localparam int CntW     = 4;
  typedef logic [CntW-1:0] cnt_t;

  // telnet command bytes
  localparam octet_t B_IAC  = 8'd255;
  localparam octet_t B_SE   = 8'd240;
  localparam octet_t B_SB   = 8'd250;
  localparam octet_t B_WILL = 8'd251;
  localparam octet_t B_WONT = 8'd252;
  localparam octet_t B_DO   = 8'd253;
  localparam octet_t B_DONT = 8'd254;

  // option codes
  localparam octet_t OPT_ECHO = 8'd1;
  localparam octet_t OPT_SUPP = 8'd3;
  localparam octet_t OPT_TERM = 8'd24;
  localparam octet_t TT_SEND  = 8'd1;
  localparam octet_t TT_IS    = 8'd0;

  // receive phase
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CODE = 2'd1;
  localparam logic [1:0] PH_OPT  = 2'd2;

  // pending verb
  localparam logic [2:0] V_SB   = 3'd0;
  localparam logic [2:0] V_WILL = 3'd1;
  localparam logic [2:0] V_WONT = 3'd2;
  localparam logic [2:0] V_DO   = 3'd3;
  localparam logic [2:0] V_DONT = 3'd4;

  // data sink
  localparam logic [1:0] SINK_TERM    = 2'd0;
  localparam logic [1:0] SINK_TTYPE   = 2'd1;
  localparam logic [1:0] SINK_DISCARD = 2'd2;

  // destination codes
  localparam logic DEST_SERVER = 1'b0;
  localparam logic DEST_TERM   = 1'b1;

endpackage

>>> sv/telnet_receive_negotiator_unit.sv
// Telnet receive negotiator: command parser, option replies, reply burst buffer.
// Depends on trn_pkg.
//
// One received byte is accepted per beat on the in channel; its whole reply
// (zero to ten bytes) is worked out in the same cycle and loaded into a
// ten-entry shift buffer that drains one byte per out beat, the final byte
// marked by last. A byte that causes no reply loads an empty burst, so such bytes
// flow at one per cycle; a byte with n replies occupies the out channel for n
// beats, and the next received byte is taken in the cycle the last reply
// beat leaves. Terminal data bytes go out with destination 1, negotiation
// replies with destination 0. Subnegotiation for options other than
// terminal type is discarded.
module telnet_receive_negotiator_unit
  import trn_pkg::*;
#(
  parameter int TERMINAL_COUNT = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       destination,
  output logic [7:0] out_byte,
  output logic       last
);

  localparam int ChoiceW = $clog2(TERMINAL_COUNT + 1);

  // parser state
  logic [1:0]         rx_phase, rx_phase_next;
  logic [2:0]         pending_verb, pending_verb_next;
  logic [1:0]         data_sink, data_sink_next;
  logic [ChoiceW-1:0] terminal_choice, terminal_choice_next;

  // reply buffer
  octet_t burst_buf [MaxBurst];
  logic   burst_dest;
  cnt_t   burst_cnt;

  // reply computed for the byte on the input
  octet_t new_buf [MaxBurst];
  logic   new_dest;
  cnt_t   new_cnt;

  logic in_acc, out_acc;

  assign out_valid   = (burst_cnt != '0);
  assign last        = (burst_cnt == cnt_t'(1));
  assign out_byte    = burst_buf[0];
  assign destination = burst_dest;
  assign in_ready    = (burst_cnt == '0) || (last && out_ready);
  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;

  // positive answer byte for ECHO
  function automatic octet_t yes_byte(input logic [2:0] v);
    octet_t r;
    unique case (v)
      V_DO:    r = B_WILL;
      V_DONT:  r = B_WONT;
      V_WILL:  r = B_DO;
      default: r = B_DONT;
    endcase
    return r;
  endfunction

  // parser and reply generation
  always_comb begin
    logic   sink_in;
    octet_t sink_byte;
    logic   nvt;
    for (int i = 0; i < MaxBurst; i++) new_buf[i] = '0;
    new_dest             = DEST_SERVER;
    new_cnt              = '0;
    rx_phase_next        = PH_DATA;
    pending_verb_next    = pending_verb;
    data_sink_next       = data_sink;
    terminal_choice_next = terminal_choice;
    sink_in              = 1'b0;
    sink_byte            = rx_byte;
    nvt                  = 1'b0;

    unique case (rx_phase)
      PH_CODE: begin
        priority if (rx_byte == B_IAC) begin
          sink_in = 1'b1;
        end else if (rx_byte == B_SE) begin
          data_sink_next = SINK_TERM;
        end else if (rx_byte == B_SB) begin
          pending_verb_next = V_SB;
          rx_phase_next     = PH_OPT;
        end else if (rx_byte >= B_WILL) begin
          // WILL..DONT; IAC already handled above
          pending_verb_next = 3'(rx_byte - B_WILL) + V_WILL;
          rx_phase_next     = PH_OPT;
        end else begin
          // unknown command byte: back to data, no reply
        end
      end
      PH_OPT: begin
        if (pending_verb == V_SB) begin
          data_sink_next = (rx_byte == OPT_TERM) ? SINK_TTYPE : SINK_DISCARD;
        end else begin
          new_buf[0] = B_IAC;
          new_buf[2] = rx_byte;
          priority if (rx_byte == OPT_ECHO) begin
            new_buf[1] = yes_byte(pending_verb);
            new_cnt    = cnt_t'(3);
          end else if (rx_byte == OPT_SUPP) begin
            new_buf[1] = B_DO;
            if (pending_verb == V_WILL) begin
              new_buf[3] = B_IAC;
              new_buf[4] = B_WILL;
              new_buf[5] = OPT_SUPP;
              new_buf[6] = B_IAC;
              new_buf[7] = B_DO;
              new_buf[8] = OPT_ECHO;
              new_cnt    = cnt_t'(9);
            end else if (pending_verb == V_DO) begin
              new_cnt = cnt_t'(3);
            end
          end else if (rx_byte == OPT_TERM) begin
            if (pending_verb == V_DO) begin
              new_buf[1] = B_WILL;
              new_cnt    = cnt_t'(3);
            end else if (pending_verb == V_WILL) begin
              new_buf[1] = B_DONT;
              new_cnt    = cnt_t'(3);
            end
          end else begin
            // unknown option: refuse
            if (pending_verb == V_WILL) begin
              new_buf[1] = B_DONT;
              new_cnt    = cnt_t'(3);
            end else if (pending_verb == V_DO) begin
              new_buf[1] = B_WONT;
              new_cnt    = cnt_t'(3);
            end
          end
        end
      end
      default: begin
        if (rx_byte == B_IAC) rx_phase_next = PH_CODE;
        else                  sink_in = 1'b1;
      end
    endcase

    // data sink
    if (sink_in) begin
      priority if (data_sink == SINK_TERM) begin
        if (sink_byte != '0) begin
          new_buf[0] = sink_byte;
          new_dest   = DEST_TERM;
          new_cnt    = cnt_t'(1);
        end
      end else if (data_sink == SINK_TTYPE) begin
        if (sink_byte == TT_SEND) begin
          if (terminal_choice >= ChoiceW'(TERMINAL_COUNT))
            terminal_choice_next = '0;
          else
            terminal_choice_next = terminal_choice + ChoiceW'(1);
          // name index wraps to 0 after the last terminal; index 0 is NVT
          nvt = (terminal_choice_next == '0) || (TERMINAL_COUNT == 1);
          new_buf[0] = B_IAC;
          new_buf[1] = B_SB;
          new_buf[2] = OPT_TERM;
          new_buf[3] = TT_IS;
          if (nvt) begin
            new_buf[4] = "N";
            new_buf[5] = "V";
            new_buf[6] = "T";
            new_buf[7] = B_IAC;
            new_buf[8] = B_SE;
            new_cnt    = cnt_t'(9);
          end else begin
            new_buf[4] = "A";
            new_buf[5] = "N";
            new_buf[6] = "S";
            new_buf[7] = "I";
            new_buf[8] = B_IAC;
            new_buf[9] = B_SE;
            new_cnt    = cnt_t'(10);
          end
        end
      end else begin
        // discard sink drops the byte
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase        <= PH_DATA;
      pending_verb    <= V_SB;
      data_sink       <= SINK_TERM;
      terminal_choice <= '0;
      burst_cnt       <= '0;
    end else begin
      if (in_acc) begin
        rx_phase        <= rx_phase_next;
        pending_verb    <= pending_verb_next;
        data_sink       <= data_sink_next;
        terminal_choice <= terminal_choice_next;
        burst_cnt       <= new_cnt;
      end else if (out_acc) begin
        burst_cnt <= burst_cnt - cnt_t'(1);
      end
    end
  end

  // reply buffer payload: load a burst, shift one byte per out beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      burst_buf  <= new_buf;
      burst_dest <= new_dest;
    end else if (out_acc) begin
      for (int i = 0; i < MaxBurst - 1; i++) burst_buf[i] <= burst_buf[i+1];
      burst_buf[MaxBurst-1] <= '0;
    end
  end

endmodule

>>> sv/telnet_receive_negotiator_unit_checker.sv
// Port-level checks for telnet_receive_negotiator_unit, bound to the top level.
// Depends on trn_pkg.
module telnet_receive_negotiator_unit_checker
  import trn_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       destination,
  input logic [7:0] out_byte,
  input logic       last
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(last) && $stable(destination))
    else $error("output beat changed while stalled");

  // terminal data is always a single-beat burst
  a_term_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && destination == DEST_TERM |-> last)
    else $error("terminal byte not marked last");

  // no new input while a burst is mid-way
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken during an unfinished burst");

  // a burst continues after a non-final beat leaves
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("burst ended without last");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind telnet_receive_negotiator_unit telnet_receive_negotiator_unit_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .destination(destination),
  .out_byte(out_byte), .last(last)
);
